// ----- hw/rtl/spf_pkg.sv -----
// Shared types and constants of the sample packet framer.
package spf_pkg;

    // Commands carried in the command field of an input item.
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_CONFIG = 2'd2;

    // Work handed from the front end to the byte engine.
    localparam logic [2:0] JOB_ERROR       = 3'd0;
    localparam logic [2:0] JOB_RAW         = 3'd1;
    localparam logic [2:0] JOB_SAMPLE      = 3'd2;
    localparam logic [2:0] JOB_SAMPLE_LAST = 3'd3;
    localparam logic [2:0] JOB_CONFIG      = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RESOLUTION  = 3'd0;
    localparam logic [2:0] CFG_VREF        = 3'd1;
    localparam logic [2:0] CFG_CHANNEL     = 3'd2;
    localparam logic [2:0] CFG_SAMPLE_RATE = 3'd3;
    localparam logic [2:0] CFG_BASELINE    = 3'd4;
    localparam logic [2:0] CFG_GAIN        = 3'd5;

    // Configuration register reset values.
    localparam logic [7:0]  RESOLUTION_RST  = 8'd12;
    localparam logic [15:0] VREF_RST        = 16'd3300;
    localparam logic [7:0]  CHANNEL_RST     = 8'd0;
    localparam logic [15:0] SAMPLE_RATE_RST = 16'd1000;
    localparam logic [15:0] BASELINE_RST    = 16'd0;
    localparam logic [15:0] GAIN_RST        = 16'd32767;

    // Framing constants.
    localparam logic [7:0]  MAX_SAMPLES  = 8'd64;
    localparam logic [7:0]  SYNC_FIRST   = 8'd170;
    localparam logic [7:0]  SYNC_SECOND  = 8'd85;
    localparam logic [7:0]  TYPE_RAW     = 8'd1;
    localparam logic [7:0]  TYPE_CONFIG  = 8'd2;
    localparam logic [15:0] RAW_LEN_BASE = 16'd9;
    localparam logic [15:0] CONFIG_LEN   = 16'd18;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  seq;
        logic [31:0] time_ms;
        logic [7:0]  sample_count;
        logic [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       packet_end;
        logic       error;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  seq;
        logic [31:0] time_ms;
        logic [7:0]  sample_count;
        logic [15:0] sample;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] index;
        logic [15:0] data;
    } cfg_write_t;

endpackage

// ----- hw/rtl/sample_packet_framer_crc16.sv -----
// Top level of the sample packet framer: front end, job queue and byte engine.
// Each item produces its bytes one per cycle, while the output is not stalled, through
// a single registered output stage: a sample gives 2 bytes (4 when it closes the packet
// and the CRC follows), a raw packet start 11, a configuration packet 22, and a
// rejected item a single error item. The front end checks items on arrival and parks up to
// QUEUE_DEPTH jobs, so items keep being accepted while earlier bytes drain or the
// output is stalled. The first byte of an item passes the queue entry, job and output registers.
// Configuration writes are always ready and take effect on the next cycle.
module sample_packet_framer_crc16 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  spf_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output spf_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic                push_valid;
    logic                push_ready;
    spf_pkg::job_t       push_job;
    logic                pop_valid;
    logic                pop_ready;
    spf_pkg::job_t       pop_job;
    spf_pkg::cfg_write_t cfg_wr;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    spf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    spf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    spf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- hw/rtl/spf_front.sv -----
// Front end: checks each item against the packet state and queues a job.
module spf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  spf_pkg::in_item_t item,
    output logic              push_valid,
    input  logic              push_ready,
    output spf_pkg::job_t     push_job
);

    logic       open_reg;
    logic       open_next;
    logic [7:0] left_reg;
    logic [7:0] left_next;
    logic       accept;
    logic [2:0] kind;

    assign accept     = item_valid && push_ready;
    assign item_stall = !push_ready;
    assign push_valid = item_valid;

    always_comb
    begin
        kind      = spf_pkg::JOB_ERROR;
        open_next = open_reg;
        left_next = left_reg;
        case (item.command)
            spf_pkg::CMD_START:
            begin
                if (!open_reg && item.sample_count != 8'd0 &&
                    item.sample_count <= spf_pkg::MAX_SAMPLES)
                begin
                    kind = spf_pkg::JOB_RAW;
                    if (accept)
                    begin
                        open_next = 1'b1;
                        left_next = item.sample_count;
                    end
                end
            end
            spf_pkg::CMD_SAMPLE:
            begin
                if (open_reg)
                begin
                    kind = (left_reg == 8'd1) ? spf_pkg::JOB_SAMPLE_LAST
                                              : spf_pkg::JOB_SAMPLE;
                    if (accept)
                    begin
                        left_next = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                        begin
                            open_next = 1'b0;
                        end
                    end
                end
            end
            spf_pkg::CMD_CONFIG:
            begin
                if (!open_reg)
                begin
                    kind = spf_pkg::JOB_CONFIG;
                end
            end
            default:
            begin
                kind = spf_pkg::JOB_ERROR;
            end
        endcase
    end

    always_comb
    begin
        push_job.kind         = kind;
        push_job.seq          = item.seq;
        push_job.time_ms      = item.time_ms;
        push_job.sample_count = item.sample_count;
        push_job.sample       = item.sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            left_reg <= 8'd0;
        end
        else
        begin
            open_reg <= open_next;
            left_reg <= left_next;
        end
    end

endmodule

// ----- hw/rtl/spf_queue.sv -----
// Small job queue between the front end and the byte engine.
module spf_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  spf_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output spf_pkg::job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    spf_pkg::job_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/spf_back.sv -----
// Byte engine: turns queued jobs into output bytes and keeps the running CRC.
module spf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  spf_pkg::cfg_write_t cfg_wr,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  spf_pkg::job_t       pop_job,
    output logic                result_valid,
    input  logic                result_stall,
    output spf_pkg::out_item_t  result
);

    // CRC-16/CCITT-FALSE over one byte, most significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ spf_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [7:0]         resolution_reg;
    logic [15:0]        vref_reg;
    logic [7:0]         channel_reg;
    logic [15:0]        rate_reg;
    logic [15:0]        baseline_reg;
    logic signed [15:0] gain_reg;

    spf_pkg::job_t      job_reg;
    logic               job_valid_reg;
    logic               job_valid_next;
    logic [4:0]         idx_reg;
    logic [4:0]         idx_next;
    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    spf_pkg::out_item_t out_reg;

    logic               step;
    logic               load;
    logic [7:0]         byte_val;
    logic               crc_it;
    logic               is_last;
    logic               pkt_end;
    logic               err;
    logic [15:0]        crc_base;
    logic [15:0]        len;
    logic               is_raw;

    assign step         = job_valid_reg && (!out_valid_reg || !result_stall);
    assign pop_ready    = !job_valid_reg || (step && is_last);
    assign load         = pop_valid && pop_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign is_raw = (job_reg.kind == spf_pkg::JOB_RAW);
    assign len    = is_raw ? (spf_pkg::RAW_LEN_BASE + {7'd0, job_reg.sample_count, 1'b0})
                           : spf_pkg::CONFIG_LEN;

    always_comb
    begin
        byte_val = 8'h00;
        crc_it   = 1'b0;
        is_last  = 1'b0;
        pkt_end  = 1'b0;
        err      = 1'b0;
        crc_base = crc_reg;
        case (job_reg.kind)
            spf_pkg::JOB_RAW, spf_pkg::JOB_CONFIG:
            begin
                case (idx_reg)
                    5'd0: byte_val = spf_pkg::SYNC_FIRST;
                    5'd1: byte_val = spf_pkg::SYNC_SECOND;
                    5'd2: byte_val = len[7:0];
                    5'd3: byte_val = len[15:8];
                    5'd4:
                    begin
                        // The CRC restarts at the type byte.
                        byte_val = is_raw ? spf_pkg::TYPE_RAW : spf_pkg::TYPE_CONFIG;
                        crc_it   = 1'b1;
                        crc_base = spf_pkg::CRC_INIT;
                    end
                    5'd5: begin byte_val = job_reg.seq;            crc_it = 1'b1; end
                    5'd6: begin byte_val = job_reg.time_ms[7:0];   crc_it = 1'b1; end
                    5'd7: begin byte_val = job_reg.time_ms[15:8];  crc_it = 1'b1; end
                    5'd8: begin byte_val = job_reg.time_ms[23:16]; crc_it = 1'b1; end
                    5'd9: begin byte_val = job_reg.time_ms[31:24]; crc_it = 1'b1; end
                    5'd10:
                    begin
                        crc_it = 1'b1;
                        if (is_raw)
                        begin
                            byte_val = job_reg.sample_count;
                            is_last  = 1'b1;
                        end
                        else
                        begin
                            byte_val = resolution_reg;
                        end
                    end
                    5'd11: begin byte_val = vref_reg[7:0];      crc_it = 1'b1; end
                    5'd12: begin byte_val = vref_reg[15:8];     crc_it = 1'b1; end
                    5'd13: begin byte_val = channel_reg;        crc_it = 1'b1; end
                    5'd14: begin byte_val = rate_reg[7:0];      crc_it = 1'b1; end
                    5'd15: begin byte_val = rate_reg[15:8];     crc_it = 1'b1; end
                    5'd16: begin byte_val = baseline_reg[7:0];  crc_it = 1'b1; end
                    5'd17: begin byte_val = baseline_reg[15:8]; crc_it = 1'b1; end
                    5'd18: begin byte_val = gain_reg[7:0];      crc_it = 1'b1; end
                    5'd19: begin byte_val = gain_reg[15:8];     crc_it = 1'b1; end
                    5'd20: byte_val = crc_reg[7:0];
                    5'd21:
                    begin
                        byte_val = crc_reg[15:8];
                        is_last  = 1'b1;
                        pkt_end  = 1'b1;
                    end
                    default: byte_val = 8'h00;
                endcase
            end
            spf_pkg::JOB_SAMPLE, spf_pkg::JOB_SAMPLE_LAST:
            begin
                case (idx_reg)
                    5'd0: begin byte_val = job_reg.sample[7:0]; crc_it = 1'b1; end
                    5'd1:
                    begin
                        byte_val = job_reg.sample[15:8];
                        crc_it   = 1'b1;
                        is_last  = (job_reg.kind == spf_pkg::JOB_SAMPLE);
                    end
                    5'd2: byte_val = crc_reg[7:0];
                    5'd3:
                    begin
                        byte_val = crc_reg[15:8];
                        is_last  = 1'b1;
                        pkt_end  = 1'b1;
                    end
                    default: byte_val = 8'h00;
                endcase
            end
            default:
            begin
                is_last = 1'b1;
                err     = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 5'd0 : idx_reg + 5'd1;
            if (crc_it)
            begin
                crc_next = crc_byte(crc_base, byte_val);
            end
            else if (pkt_end)
            begin
                crc_next = spf_pkg::CRC_INIT;
            end
            if (is_last)
            begin
                job_valid_next = 1'b0;
            end
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            job_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= pop_job;
        end
        if (step)
        begin
            out_reg.out_byte   <= byte_val;
            out_reg.run_end    <= is_last;
            out_reg.packet_end <= pkt_end;
            out_reg.error      <= err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 5'd0;
            crc_reg       <= spf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= spf_pkg::RESOLUTION_RST;
            vref_reg       <= spf_pkg::VREF_RST;
            channel_reg    <= spf_pkg::CHANNEL_RST;
            rate_reg       <= spf_pkg::SAMPLE_RATE_RST;
            baseline_reg   <= spf_pkg::BASELINE_RST;
            gain_reg       <= spf_pkg::GAIN_RST;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                spf_pkg::CFG_RESOLUTION:  resolution_reg <= cfg_wr.data[7:0];
                spf_pkg::CFG_VREF:        vref_reg       <= cfg_wr.data;
                spf_pkg::CFG_CHANNEL:     channel_reg    <= cfg_wr.data[7:0];
                spf_pkg::CFG_SAMPLE_RATE: rate_reg       <= cfg_wr.data;
                spf_pkg::CFG_BASELINE:    baseline_reg   <= cfg_wr.data;
                spf_pkg::CFG_GAIN:        gain_reg       <= cfg_wr.data;
                default:                  resolution_reg <= resolution_reg;
            endcase
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sample packet framer with CRC-16 trailer.
module testbench;

    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [7:0]  SYNC_A      = 8'hAA;
    localparam logic [7:0]  SYNC_B      = 8'h55;
    localparam logic [7:0]  KIND_RAW    = 8'd1;
    localparam logic [7:0]  KIND_CONFIG = 8'd2;
    localparam logic [7:0]  MAX_COUNT   = 8'd64;
    localparam logic [15:0] RAW_LEN     = 16'd9;
    localparam logic [15:0] CONFIG_LEN  = 16'd18;
    localparam logic [15:0] CRC_SEED    = 16'hFFFF;
    localparam logic [15:0] CCITT_POLY  = 16'h1021;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          CHUNK_ITEMS = 75;

    localparam spf_pkg::out_item_t REJECTED =
        '{out_byte: 8'h00, run_end: 1'b1, packet_end: 1'b0, error: 1'b1};

    typedef struct packed {
        spf_pkg::in_item_t it;
        logic              known;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    spf_pkg::in_item_t  item;
    logic               result_valid;
    logic               result_stall;
    spf_pkg::out_item_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    // Framer state and register copies kept by the predictor.
    logic        pkt_open = 1'b0;
    logic [7:0]  samples_due = 8'd0;
    logic [15:0] crc_acc = 16'hFFFF;
    logic [7:0]  set_resolution = 8'd12;
    logic [15:0] set_vref = 16'd3300;
    logic [7:0]  set_channel = 8'd0;
    logic [15:0] set_rate = 16'd1000;
    logic [15:0] set_baseline = 16'd0;
    logic [15:0] set_gain = 16'h7FFF;

    spf_pkg::out_item_t expected_bytes[$];
    int items_taken = 0;
    int failures = 0;
    int cycles = 0;
    bit calm = 1'b0;

    // Rows marked known are rejections whose single error item is typed in directly.
    row_t directed_rows [15] = '{
        '{'{spf_pkg::CMD_SAMPLE, 8'h00, 32'h00000000, 8'h00, 16'h1234}, 1'b1},
        '{'{CMD_UNUSED, 8'hFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF}, 1'b1},
        '{'{spf_pkg::CMD_START, 8'h01, 32'h00000001, 8'd0, 16'h0000}, 1'b1},
        '{'{spf_pkg::CMD_START, 8'h02, 32'h00000002, 8'd65, 16'h0000}, 1'b1},
        '{'{spf_pkg::CMD_START, 8'h03, 32'h00000003, 8'd255, 16'h0000}, 1'b1},
        '{'{spf_pkg::CMD_CONFIG, 8'h00, 32'h00000000, 8'h00, 16'h0000}, 1'b0},
        '{'{spf_pkg::CMD_START, 8'hFF, 32'hFFFFFFFF, 8'd1, 16'h0000}, 1'b0},
        '{'{spf_pkg::CMD_START, 8'h10, 32'h00000010, 8'd2, 16'h0000}, 1'b1},
        '{'{spf_pkg::CMD_CONFIG, 8'h11, 32'h00000011, 8'h00, 16'h0000}, 1'b1},
        '{'{spf_pkg::CMD_SAMPLE, 8'h00, 32'h00000000, 8'h00, 16'hFFFF}, 1'b0},
        '{'{spf_pkg::CMD_START, 8'h5A, 32'h80000001, 8'd2, 16'h0000}, 1'b0},
        '{'{spf_pkg::CMD_SAMPLE, 8'h00, 32'h00000000, 8'h00, 16'h0000}, 1'b0},
        '{'{spf_pkg::CMD_SAMPLE, 8'h00, 32'h00000000, 8'h00, 16'h8001}, 1'b0},
        '{'{spf_pkg::CMD_SAMPLE, 8'hA5, 32'h5A5A5A5A, 8'hC3, 16'h3C3C}, 1'b1},
        '{'{spf_pkg::CMD_CONFIG, 8'hFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF}, 1'b0}
    };

    sample_packet_framer_crc16 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        repeat (8) r = r[15] ? ((r << 1) ^ CCITT_POLY) : (r << 1);
        return r;
    endfunction

    function automatic void put_byte(input logic [7:0] b, input logic covered,
                                     input logic closes);
        spf_pkg::out_item_t r;
        r.out_byte = b;
        r.run_end = 1'b0;
        r.packet_end = closes;
        r.error = 1'b0;
        expected_bytes.push_back(r);
        if (covered)
            crc_acc = crc_update(crc_acc, b);
    endfunction

    function automatic void put_word(input logic [15:0] w, input logic covered);
        put_byte(w[7:0], covered, 1'b0);
        put_byte(w[15:8], covered, 1'b0);
    endfunction

    function automatic void put_header(input logic [15:0] len, input logic [7:0] kind,
                                       input logic [7:0] seq, input logic [31:0] stamp);
        put_byte(SYNC_A, 1'b0, 1'b0);
        put_byte(SYNC_B, 1'b0, 1'b0);
        put_word(len, 1'b0);
        crc_acc = CRC_SEED;
        put_byte(kind, 1'b1, 1'b0);
        put_byte(seq, 1'b1, 1'b0);
        put_word(stamp[15:0], 1'b1);
        put_word(stamp[31:16], 1'b1);
    endfunction

    function automatic void put_crc();
        put_byte(crc_acc[7:0], 1'b0, 1'b0);
        put_byte(crc_acc[15:8], 1'b0, 1'b1);
        crc_acc = CRC_SEED;
    endfunction

    // Appends the bytes that one accepted item produces and advances the framing state.
    function automatic void frame_item(input spf_pkg::in_item_t it);
        spf_pkg::out_item_t tail;
        logic rejected;
        rejected = 1'b0;
        case (it.command)
            spf_pkg::CMD_START:
                if (pkt_open || it.sample_count == 8'd0 || it.sample_count > MAX_COUNT)
                    rejected = 1'b1;
                else
                begin
                    put_header(RAW_LEN + {7'd0, it.sample_count, 1'b0}, KIND_RAW,
                               it.seq, it.time_ms);
                    put_byte(it.sample_count, 1'b1, 1'b0);
                    pkt_open = 1'b1;
                    samples_due = it.sample_count;
                end
            spf_pkg::CMD_SAMPLE:
                if (!pkt_open)
                    rejected = 1'b1;
                else
                begin
                    put_word(it.sample, 1'b1);
                    samples_due = samples_due - 8'd1;
                    if (samples_due == 8'd0)
                    begin
                        put_crc();
                        pkt_open = 1'b0;
                    end
                end
            spf_pkg::CMD_CONFIG:
                if (pkt_open)
                    rejected = 1'b1;
                else
                begin
                    put_header(CONFIG_LEN, KIND_CONFIG, it.seq, it.time_ms);
                    put_byte(set_resolution, 1'b1, 1'b0);
                    put_word(set_vref, 1'b1);
                    put_byte(set_channel, 1'b1, 1'b0);
                    put_word(set_rate, 1'b1);
                    put_word(set_baseline, 1'b1);
                    put_word(set_gain, 1'b1);
                    put_crc();
                end
            default:
                rejected = 1'b1;
        endcase
        if (rejected)
            expected_bytes.push_back(REJECTED);
        else
        begin
            tail = expected_bytes.pop_back();
            tail.run_end = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic spf_pkg::in_item_t any_item();
        spf_pkg::in_item_t it;
        it.command = 2'($urandom_range(0, 3));
        it.seq = 8'($urandom_range(0, 255));
        it.time_ms = $urandom;
        it.sample_count = 8'($urandom_range(0, 255));
        it.sample = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    task automatic send_item(input spf_pkg::in_item_t it, input logic known);
        int gap;
        if ($urandom_range(0, 29) == 0)
            calm = !calm;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        items_taken++;
        if (known)
            expected_bytes.push_back(REJECTED);
        else
            frame_item(it);
    endtask

    // Mostly well-formed packets with random content; about one item in ten is noise.
    task automatic random_items(input int budget);
        spf_pkg::in_item_t it;
        int pick;
        int left;
        left = budget;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            it = any_item();
            if (pick >= 10)
            begin
                if (pkt_open)
                    it.command = spf_pkg::CMD_SAMPLE;
                else if (pick < 35)
                    it.command = spf_pkg::CMD_CONFIG;
                else
                begin
                    it.command = spf_pkg::CMD_START;
                    pick = $urandom_range(0, 99);
                    if (pick < 75)
                        it.sample_count = 8'($urandom_range(1, 4));
                    else if (pick < 90)
                        it.sample_count = 8'($urandom_range(1, 64));
                    else
                        it.sample_count = MAX_COUNT;
                end
            end
            send_item(it, 1'b0);
            left--;
        end
        while (pkt_open)
        begin
            it = any_item();
            it.command = spf_pkg::CMD_SAMPLE;
            send_item(it, 1'b0);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            spf_pkg::CFG_RESOLUTION:  set_resolution = val[7:0];
            spf_pkg::CFG_VREF:        set_vref = val;
            spf_pkg::CFG_CHANNEL:     set_channel = val[7:0];
            spf_pkg::CFG_SAMPLE_RATE: set_rate = val;
            spf_pkg::CFG_BASELINE:    set_baseline = val;
            spf_pkg::CFG_GAIN:        set_gain = val;
            default: ;
        endcase
    endtask

    // Registers change only once every outstanding byte has come out.
    task automatic write_settings(input logic [7:0] res, input logic [15:0] vref,
                                  input logic [7:0] chan, input logic [15:0] rate,
                                  input logic [15:0] base, input logic [15:0] gain);
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(spf_pkg::CFG_RESOLUTION, {8'd0, res});
        write_reg(spf_pkg::CFG_VREF, vref);
        write_reg(spf_pkg::CFG_CHANNEL, {8'd0, chan});
        write_reg(spf_pkg::CFG_SAMPLE_RATE, rate);
        write_reg(spf_pkg::CFG_BASELINE, base);
        write_reg(spf_pkg::CFG_GAIN, gain);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[k])
            send_item(directed_rows[k].it, directed_rows[k].known);
        write_settings(8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        random_items(CHUNK_ITEMS);
        write_settings(8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        random_items(CHUNK_ITEMS);
        write_settings(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'h8000);
        random_items(CHUNK_ITEMS);
        repeat (2)
        begin
            write_settings(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                           8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            random_items(CHUNK_ITEMS);
        end
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Random stalls on the result side, plus one long hold that backs up the input.
    initial
    begin : result_side
        int hold;
        bit pressed;
        hold = 0;
        pressed = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (!pressed && items_taken >= 60)
            begin
                pressed = 1'b1;
                result_stall <= 1'b1;
                hold = 400;
            end
            else if (result_stall)
            begin
                result_stall <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(0, 8);
            end
            else
            begin
                result_stall <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        spf_pkg::out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected item: out_byte %0h error %0b", result.out_byte,
                       result.error);
                failures++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                compare_field("out_byte", want.out_byte, result.out_byte);
                compare_field("run_end", {7'd0, want.run_end}, {7'd0, result.run_end});
                compare_field("packet_end", {7'd0, want.packet_end},
                              {7'd0, result.packet_end});
                compare_field("error", {7'd0, want.error}, {7'd0, result.error});
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ----- files.f -----
hw/rtl/spf_pkg.sv
hw/rtl/spf_front.sv
hw/rtl/spf_queue.sv
hw/rtl/spf_back.sv
hw/rtl/sample_packet_framer_crc16.sv
tb/testbench.sv
